[src/p_median_cost_and_assignment_top_macros.svh]
// Assertion macros used by the p-median evaluator top level.
`ifndef P_MEDIAN_COST_AND_ASSIGNMENT_TOP_MACROS_SVH
`define P_MEDIAN_COST_AND_ASSIGNMENT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PMCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PMCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/pmca_pkg.sv]
// Shared constants, types and codes of the p-median evaluator.
`timescale 1ns / 1ps
package pmca_pkg;

  localparam int MAX_CUSTOMERS  = 256;
  localparam int MAX_CANDIDATES = 256;
  localparam int MAX_MEDIANS    = 16;
  localparam int DIST_W         = 24;

  localparam int CUST_W = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
  localparam int SLOT_W = (MAX_MEDIANS > 1) ? $clog2(MAX_MEDIANS) : 1;
  localparam int TABLE_DEPTH = MAX_CUSTOMERS * MAX_CANDIDATES;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Counter widths able to hold the configured counts and the maxima.
  localparam int CUST_CNT_W = (CUST_W + 1 > 9) ? CUST_W + 1 : 9;
  localparam int MED_CNT_W  = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;

  localparam int CAND_FLD_W = 8;
  localparam int COST_W     = 16;
  localparam int COST_FRAC  = 8;
  localparam int TOTAL_W    = 40;
  localparam int SUM_W      = DIST_W + ((MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1);
  localparam int PROD_W     = SUM_W + COST_W;

  // Opcodes carried on in_tuser.
  localparam logic [1:0] OP_WRITE_DIST = 2'd0;
  localparam logic [1:0] OP_SET_SLOT   = 2'd1;
  localparam logic [1:0] OP_EVALUATE   = 2'd2;
  localparam logic [1:0] OP_QUERY      = 2'd3;

  // Result kinds carried on out_tuser.
  localparam logic KIND_COST   = 1'b0;
  localparam logic KIND_ASSIGN = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_PER_KM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOMER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_COUNT   = 2'd2;

  typedef struct packed {
    logic              reach;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // One table lookup issued by the sequencer.
  typedef struct packed {
    logic                  valid;
    logic                  first;     // slot 0 of a customer
    logic                  last;      // last slot of a customer
    logic                  job_last;  // last lookup of the whole item
    logic                  ok;        // row and column inside the table
    logic [CAND_FLD_W-1:0] cand;
  } probe_t;

  // Nearest median of one customer, reported after its last slot.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  found;
    logic [DIST_W-1:0]     distance;
    logic [CAND_FLD_W-1:0] cand;
  } near_t;

endpackage

[src/pmca_dist_mem.sv]
// Distance table memory with a clearing pass after reset.
`timescale 1ns / 1ps
module pmca_dist_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [pmca_pkg::ADDR_W-1:0]   wr_addr,
  input  pmca_pkg::entry_t              wr_data,
  input  logic [pmca_pkg::ADDR_W-1:0]   rd_addr,
  output pmca_pkg::entry_t              rd_data,
  output logic                          clearing
);

  pmca_pkg::entry_t mem [pmca_pkg::TABLE_DEPTH];

  logic [pmca_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                        clearing_r, clearing_nxt;
  pmca_pkg::entry_t            rd_data_r;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + pmca_pkg::ADDR_W'(1);
      if (clr_cnt_r == pmca_pkg::ADDR_W'(pmca_pkg::TABLE_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

[src/pmca_nearest.sv]
// Shared compare unit that tracks the nearest reachable median of a customer.
`timescale 1ns / 1ps
module pmca_nearest (
  input  logic               clk,
  input  logic               rst_n,
  input  pmca_pkg::probe_t   probe,
  input  pmca_pkg::entry_t   entry,
  output pmca_pkg::near_t    result
);

  logic                            found_r, found_nxt;
  logic [pmca_pkg::DIST_W-1:0]     best_d_r, best_d_nxt;
  logic [pmca_pkg::CAND_FLD_W-1:0] best_c_r, best_c_nxt;
  pmca_pkg::near_t                 result_r, result_nxt;
  logic                            reach;

  assign reach = entry.reach & probe.ok;

  always_comb begin
    found_nxt  = found_r;
    best_d_nxt = best_d_r;
    best_c_nxt = best_c_r;
    if (probe.valid) begin
      // Slot 0 restarts the search; its candidate stands when nothing is reachable.
      if (probe.first) begin
        found_nxt  = reach;
        best_d_nxt = entry.distance;
        best_c_nxt = probe.cand;
      end else if (reach && (!found_r || (entry.distance < best_d_r))) begin
        found_nxt  = 1'b1;
        best_d_nxt = entry.distance;
        best_c_nxt = probe.cand;
      end
    end
    result_nxt.valid    = probe.valid & probe.last;
    result_nxt.last     = probe.job_last;
    result_nxt.found    = found_nxt;
    result_nxt.distance = found_nxt ? best_d_nxt : '0;
    result_nxt.cand     = best_c_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r        <= 1'b0;
      result_r.valid <= 1'b0;
    end else begin
      found_r        <= found_nxt;
      result_r.valid <= result_nxt.valid;
    end
    best_d_r          <= best_d_nxt;
    best_c_r          <= best_c_nxt;
    result_r.last     <= result_nxt.last;
    result_r.found    <= result_nxt.found;
    result_r.distance <= result_nxt.distance;
    result_r.cand     <= result_nxt.cand;
  end

  assign result = result_r;

endmodule

[src/p_median_cost_and_assignment_top.sv]
// Top level of the p-median evaluator: sequencer, median slots, cost path.
//
//  Channel  Ports                        Beat carries
//  in       in_tvalid/tready/tdata/tuser one load, evaluate or query item
//  out      out_tvalid/tready/tdata/tuser one cost or assignment result
//  cfg      cfg_valid/ready/index/data   one configuration register write
//
// A query scans the m slots in use for one customer and an evaluate scans
// them for each of the n customers, with n customers and m slots in use:
// one table lookup per cycle through the single memory read port.
// After reset a clearing pass marks every table entry unreachable; no item
// is taken during it, while configuration writes are.
// A result waits in the output register; the sequencer holds its last step
// until that register is free.
`timescale 1ns / 1ps
`include "p_median_cost_and_assignment_top_macros.svh"
module p_median_cost_and_assignment_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // customer_index[7:0], candidate_index[15:8], slot_index[19:16],
  // distance[43:20], is_reachable[44], zero[47:45]
  input  logic [47:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // total_cost[39:0], assigned_candidate[47:40], nearest_distance[71:48],
  // customer_served[72], zero[79:73]
  output logic [79:0] out_tdata,
  // result_kind[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam int CUST_W    = pmca_pkg::CUST_W;
  localparam int SLOT_W    = pmca_pkg::SLOT_W;
  localparam int ADDR_W    = pmca_pkg::ADDR_W;
  localparam int DIST_W    = pmca_pkg::DIST_W;
  localparam int CAND_W    = pmca_pkg::CAND_FLD_W;
  localparam int CCNT_W    = pmca_pkg::CUST_CNT_W;
  localparam int MCNT_W    = pmca_pkg::MED_CNT_W;
  localparam int SUM_W     = pmca_pkg::SUM_W;
  localparam int PROD_W    = pmca_pkg::PROD_W;
  localparam int TOTAL_W   = pmca_pkg::TOTAL_W;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [31:0] row,
                                                 input logic [31:0] col);
    logic [31:0] lin;
    lin = row * 32'(pmca_pkg::MAX_CANDIDATES) + col;
    return lin[ADDR_W-1:0];
  endfunction

  // Input fields.
  logic [1:0]        in_op;
  logic [7:0]        in_cust;
  logic [7:0]        in_cand;
  logic [3:0]        in_slot;
  logic [DIST_W-1:0] in_dist;
  logic              in_reach;
  logic              in_acc;

  assign in_op    = in_tuser;
  assign in_cust  = in_tdata[7:0];
  assign in_cand  = in_tdata[15:8];
  assign in_slot  = in_tdata[19:16];
  assign in_dist  = in_tdata[43:20];
  assign in_reach = in_tdata[44];

  // Configuration registers.
  logic [pmca_pkg::COST_W-1:0] cost_r;
  logic [8:0]                  ccount_r;
  logic [4:0]                  mcount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r   <= 16'd256;
      ccount_r <= 9'd256;
      mcount_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmca_pkg::CFG_COST_PER_KM:    cost_r   <= cfg_data;
        pmca_pkg::CFG_CUSTOMER_COUNT: ccount_r <= cfg_data[8:0];
        pmca_pkg::CFG_MEDIAN_COUNT:   mcount_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [CCNT_W-1:0] n_use;
  logic [MCNT_W-1:0] m_use;

  assign n_use = (CCNT_W'(ccount_r) < CCNT_W'(pmca_pkg::MAX_CUSTOMERS)) ?
                 CCNT_W'(ccount_r) : CCNT_W'(pmca_pkg::MAX_CUSTOMERS);
  assign m_use = (MCNT_W'(mcount_r) < MCNT_W'(pmca_pkg::MAX_MEDIANS)) ?
                 MCNT_W'(mcount_r) : MCNT_W'(pmca_pkg::MAX_MEDIANS);

  // Sequencer state.
  logic [2:0]        state_r, state_nxt;
  logic              eval_r, eval_nxt;
  logic              qok_r, qok_nxt;
  logic [CUST_W-1:0] cust_r, cust_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              q_found_r, q_found_nxt;
  logic [DIST_W-1:0] q_dist_r, q_dist_nxt;
  logic [CAND_W-1:0] q_cand_r, q_cand_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [79:0]       out_data_r, out_data_nxt;
  logic              out_kind_r, out_kind_nxt;

  logic [CAND_W-1:0] slots_r [pmca_pkg::MAX_MEDIANS];

  pmca_pkg::probe_t  probe_r, probe_nxt;
  pmca_pkg::near_t   near;
  pmca_pkg::entry_t  rd_entry;
  pmca_pkg::entry_t  wr_entry;
  logic              clearing;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic [CAND_W-1:0] scan_cand;
  logic              last_slot;
  logic              last_cust;
  logic              col_ok;
  logic              out_free;
  logic [63:0]       shifted;
  logic [TOTAL_W-1:0] total;

  assign in_tready = (state_r == ST_IDLE) && !clearing;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Median slots: written by set-slot items, read by the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pmca_pkg::MAX_MEDIANS; i++) begin
        slots_r[SLOT_W'(i)] <= CAND_W'(i);
      end
    end else if (in_acc && (in_op == pmca_pkg::OP_SET_SLOT) &&
                 (32'(in_slot) < 32'(pmca_pkg::MAX_MEDIANS))) begin
      slots_r[SLOT_W'(in_slot)] <= in_cand;
    end
  end

  // Table writes.
  assign mem_wr_en = in_acc && (in_op == pmca_pkg::OP_WRITE_DIST) &&
                     (32'(in_cust) < 32'(pmca_pkg::MAX_CUSTOMERS)) &&
                     (32'(in_cand) < 32'(pmca_pkg::MAX_CANDIDATES));
  assign wr_addr           = tbl_addr(32'(in_cust), 32'(in_cand));
  assign wr_entry.reach    = in_reach;
  assign wr_entry.distance = in_reach ? in_dist : '0;

  // Lookup issue.
  assign scan_cand = slots_r[slot_r];
  assign col_ok    = 32'(scan_cand) < 32'(pmca_pkg::MAX_CANDIDATES);
  assign rd_addr   = tbl_addr(32'(cust_r), 32'(scan_cand));
  assign last_slot = (MCNT_W'(slot_r) == (m_use - MCNT_W'(1)));
  assign last_cust = eval_r ? (CCNT_W'(cust_r) == (n_use - CCNT_W'(1))) : 1'b1;

  always_comb begin
    probe_nxt.valid    = (state_r == ST_SCAN);
    probe_nxt.first    = (slot_r == '0);
    probe_nxt.last     = last_slot;
    probe_nxt.job_last = last_slot && last_cust;
    probe_nxt.ok       = col_ok && (eval_r || qok_r);
    probe_nxt.cand     = scan_cand;
  end

  // Cost after scaling; the product can reach the limit only if the widths grow.
  assign shifted = 64'(prod_r) >> pmca_pkg::COST_FRAC;
  assign total   = (shifted > 64'(TOTAL_MAX)) ? TOTAL_MAX : shifted[TOTAL_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    eval_nxt      = eval_r;
    qok_nxt       = qok_r;
    cust_nxt      = cust_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    q_found_nxt   = q_found_r;
    q_dist_nxt    = q_dist_r;
    q_cand_nxt    = q_cand_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;

    // Each finished customer adds its nearest distance, or is captured by a query.
    if (near.valid) begin
      if (eval_r) begin
        if (near.found) begin
          sum_nxt = sum_r + SUM_W'(near.distance);
        end
      end else begin
        q_found_nxt = near.found;
        q_dist_nxt  = near.distance;
        q_cand_nxt  = near.cand;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cust_nxt = '0;
          slot_nxt = '0;
          sum_nxt  = '0;
          case (in_op)
            pmca_pkg::OP_EVALUATE: begin
              eval_nxt  = 1'b1;
              state_nxt = ((n_use == '0) || (m_use == '0)) ? ST_MUL : ST_SCAN;
            end
            pmca_pkg::OP_QUERY: begin
              eval_nxt    = 1'b0;
              qok_nxt     = 32'(in_cust) < 32'(pmca_pkg::MAX_CUSTOMERS);
              cust_nxt    = CUST_W'(in_cust);
              q_found_nxt = 1'b0;
              q_dist_nxt  = '0;
              q_cand_nxt  = slots_r[0];
              state_nxt   = (m_use == '0) ? ST_FIN : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          slot_nxt = '0;
          cust_nxt = cust_r + CUST_W'(1);
          if (last_cust) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (near.valid && near.last) begin
          state_nxt = eval_r ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(sum_r) * PROD_W'(cost_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (eval_r) begin
            out_kind_nxt = pmca_pkg::KIND_COST;
            out_data_nxt = {40'd0, total};
          end else begin
            out_kind_nxt = pmca_pkg::KIND_ASSIGN;
            out_data_nxt = {7'd0, q_found_r, q_dist_r, q_cand_r, 40'd0};
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      probe_r.valid <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      probe_r.valid <= probe_nxt.valid;
    end
    eval_r           <= eval_nxt;
    qok_r            <= qok_nxt;
    cust_r           <= cust_nxt;
    slot_r           <= slot_nxt;
    sum_r            <= sum_nxt;
    prod_r           <= prod_nxt;
    q_found_r        <= q_found_nxt;
    q_dist_r         <= q_dist_nxt;
    q_cand_r         <= q_cand_nxt;
    out_data_r       <= out_data_nxt;
    out_kind_r       <= out_kind_nxt;
    probe_r.first    <= probe_nxt.first;
    probe_r.last     <= probe_nxt.last;
    probe_r.job_last <= probe_nxt.job_last;
    probe_r.ok       <= probe_nxt.ok;
    probe_r.cand     <= probe_nxt.cand;
  end

  pmca_dist_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_entry),
    .rd_addr  (rd_addr),
    .rd_data  (rd_entry),
    .clearing (clearing)
  );

  pmca_nearest u_nearest (
    .clk    (clk),
    .rst_n  (rst_n),
    .probe  (probe_r),
    .entry  (rd_entry),
    .result (near)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  `PMCA_ASSERT_NOW(a_no_item_while_clearing, clearing, !in_tready, "item taken during clear")
  `PMCA_ASSERT_NOW(a_near_only_in_scan, near.valid,
    (state_r == ST_SCAN) || (state_r == ST_DRAIN), "nearest result outside a scan")
  `PMCA_ASSERT_NEXT(a_work_starts, in_acc &&
    ((in_op == pmca_pkg::OP_EVALUATE) || (in_op == pmca_pkg::OP_QUERY)),
    state_r != ST_IDLE, "evaluate or query did not start")
  `PMCA_ASSERT_NOW(a_assign_has_no_cost, out_valid_r && (out_kind_r == pmca_pkg::KIND_ASSIGN),
    out_data_r[39:0] == 40'd0, "assignment result carries a cost")
  `PMCA_ASSERT_NOW(a_cost_has_no_assign, out_valid_r && (out_kind_r == pmca_pkg::KIND_COST),
    out_data_r[79:40] == 40'd0, "cost result carries an assignment")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the p-median cost and assignment evaluator.
`timescale 1ns / 1ps
module tb_top;

  localparam int STALL_LIMIT = 300000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  cust;
    logic [7:0]  cand;
    logic [3:0]  slot;
    logic [23:0] distance;
    logic        reach;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [39:0] total;
    logic [7:0]  cand;
    logic [23:0] distance;
    logic        served;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the block's state and registers.
  logic [24:0] reach_dist [0:65535];
  logic [7:0]  chosen [0:15];
  logic [15:0] km_cost = 16'd256;
  logic [8:0]  cust_limit = 9'd256;
  logic [4:0]  median_limit = 5'd1;

  item_t   items_to_send [$];
  answer_t awaited_answers [$];
  item_t   on_bus;
  int      errors = 0;
  bit      quiet = 1'b0;
  bit      hold_go = 1'b0;
  bit      hold_seen = 1'b0;
  int      hold_left = 0;
  int      idle_cycles = 0;

  p_median_cost_and_assignment_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Nearest chosen candidate of one customer; the earliest slot wins a tie.
  function automatic void closest_chosen(input logic [7:0] cust, output logic found,
                                         output logic [7:0] cand, output logic [23:0] near_d);
    logic [24:0] e;
    int used;
    int s;
    used = (median_limit > 16) ? 16 : int'(median_limit);
    found = 1'b0;
    cand = chosen[0];
    near_d = '0;
    for (s = 0; s < used; s++) begin
      e = reach_dist[{cust, chosen[4'(s)]}];
      if (e[24] && (!found || e[23:0] < near_d)) begin
        found = 1'b1;
        near_d = e[23:0];
        cand = chosen[4'(s)];
      end
    end
  endfunction

  // Applies one accepted item to the shadow state; returns 1 when it yields an answer.
  function automatic bit cost_or_assignment(input item_t it, output answer_t ans);
    int n;
    int c;
    logic [47:0] sum;
    logic [63:0] prod;
    logic found;
    logic [7:0] cand;
    logic [23:0] near_d;
    ans = '0;
    case (it.op)
      pmca_pkg::OP_WRITE_DIST: begin
        reach_dist[{it.cust, it.cand}] = it.reach ? {1'b1, it.distance} : 25'd0;
        return 1'b0;
      end
      pmca_pkg::OP_SET_SLOT: begin
        chosen[it.slot] = it.cand;
        return 1'b0;
      end
      pmca_pkg::OP_EVALUATE: begin
        n = (cust_limit > 256) ? 256 : int'(cust_limit);
        sum = '0;
        for (c = 0; c < n; c++) begin
          closest_chosen(8'(c), found, cand, near_d);
          if (found) sum += 48'(near_d);
        end
        prod = (64'(sum) * 64'(km_cost)) >> 8;
        ans.kind = pmca_pkg::KIND_COST;
        ans.total = (prod > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : prod[39:0];
        return 1'b1;
      end
      default: begin
        closest_chosen(it.cust, found, cand, near_d);
        ans.kind = pmca_pkg::KIND_ASSIGN;
        ans.cand = cand;
        ans.distance = near_d;
        ans.served = found;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin : send_items
    item_t nxt;
    answer_t ans;
    if (in_tvalid && in_tready) begin
      if (cost_or_assignment(on_bus, ans))
        awaited_answers.insert(awaited_answers.size(), ans);
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (items_to_send.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
        nxt = items_to_send.pop_front();
        on_bus <= nxt;
        in_tdata <= {3'b000, nxt.reach, nxt.distance, nxt.slot, nxt.cand, nxt.cust};
        in_tuser <= nxt.op;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    answer_t want;
    if (out_tvalid && out_tready) begin
      if (awaited_answers.size() == 0) begin
        $error("result beat with nothing outstanding: tuser %0h tdata 0x%0h",
               out_tuser, out_tdata);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        check_field("result_kind", 40'(want.kind), 40'(out_tuser[0]));
        check_field("total_cost", want.total, out_tdata[39:0]);
        check_field("assigned_candidate", 40'(want.cand), 40'(out_tdata[47:40]));
        check_field("nearest_distance", 40'(want.distance), 40'(out_tdata[71:48]));
        check_field("customer_served", 40'(want.served), 40'(out_tdata[72]));
      end
    end
    // One long hold-off lets the block back up onto its input.
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] cust, input logic [7:0] cand,
                          input logic [3:0] slot, input logic [23:0] distance,
                          input logic reach);
    item_t it;
    it = '{op: op, cust: cust, cand: cand, slot: slot, distance: distance, reach: reach};
    items_to_send.insert(items_to_send.size(), it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pmca_pkg::CFG_COST_PER_KM:    km_cost = val;
      pmca_pkg::CFG_CUSTOMER_COUNT: cust_limit = val[8:0];
      pmca_pkg::CFG_MEDIAN_COUNT:   median_limit = val[4:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every item is taken and answered, then lets trailing loads finish.
  task automatic drain();
    do @(negedge clk); while (items_to_send.size() > 0 || in_tvalid || awaited_answers.size() > 0);
    repeat (32) @(negedge clk);
  endtask

  // Small values make ties likely; the top of the range checks the field width.
  function automatic logic [23:0] pick_distance();
    case ($urandom_range(3))
      0: return 24'($urandom_range(7));
      1: return 24'($urandom_range(24'hFFFFFF));
      2: return 24'hFFFFFF - 24'($urandom_range(3));
      default: return 24'($urandom_range(4095));
    endcase
  endfunction

  task automatic plan_phase(input int count, input int cust_span, input int slot_span,
                            input bit heavy);
    logic [7:0] pool [6];
    logic [1:0] op;
    logic [7:0] cust;
    int evals;
    int r;
    int k;
    evals = 0;
    foreach (pool[i]) pool[i] = 8'($urandom_range(255));
    for (k = 0; k < slot_span; k++)
      add_item(pmca_pkg::OP_SET_SLOT, 8'($urandom_range(255)), pool[3'($urandom_range(5))],
               4'(k), pick_distance(), 1'($urandom_range(1)));
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      cust = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(cust_span - 1));
      if (r < 50) op = pmca_pkg::OP_WRITE_DIST;
      else if (r < 60) op = pmca_pkg::OP_SET_SLOT;
      else if (r < 78) op = pmca_pkg::OP_QUERY;
      else if (r < 88) op = pmca_pkg::OP_EVALUATE;
      else op = 2'($urandom_range(3));
      // A full-size evaluate walks thousands of entries, so keep those few.
      if (op == pmca_pkg::OP_EVALUATE) begin
        if (heavy && evals >= 3) op = pmca_pkg::OP_QUERY;
        else evals++;
      end
      if (r >= 88)
        add_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 4'($urandom_range(15)), 24'($urandom_range(24'hFFFFFF)),
                 1'($urandom_range(1)));
      else
        add_item(op, cust, pool[3'($urandom_range(5))], 4'($urandom_range(15)),
                 pick_distance(), $urandom_range(9) != 0);
    end
  endtask

  initial begin : stimulus
    int ph;
    int n;
    int m;
    logic [15:0] cost;
    logic [15:0] cc;
    logic [15:0] mc;
    for (int i = 0; i < 65536; i++) reach_dist[16'(i)] = '0;
    for (int i = 0; i < 16; i++) chosen[4'(i)] = 8'(i);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: one slot holding candidate 0, all customers summed.
    add_item(pmca_pkg::OP_EVALUATE, 8'd0, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_QUERY, 8'd0, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd0, 8'd0, 4'd0, 24'hFFFFFF, 1'b1);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd255, 8'd0, 4'd0, 24'h000001, 1'b1);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd1, 8'd0, 4'd0, 24'h123456, 1'b0);
    add_item(pmca_pkg::OP_QUERY, 8'd0, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_QUERY, 8'd255, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_QUERY, 8'd1, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_EVALUATE, 8'hFF, 8'hFF, 4'hF, 24'hFFFFFF, 1'b1);
    add_item(pmca_pkg::OP_SET_SLOT, 8'd0, 8'd255, 4'd15, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd7, 8'd255, 4'd0, 24'd0, 1'b1);
    add_item(pmca_pkg::OP_QUERY, 8'd7, 8'd0, 4'd0, 24'd0, 1'b0);
    drain();

    // All sixteen slots, largest cost: duplicate slots and equal distances.
    write_reg(pmca_pkg::CFG_COST_PER_KM, 16'hFFFF);
    write_reg(pmca_pkg::CFG_MEDIAN_COUNT, 16'd16);
    add_item(pmca_pkg::OP_SET_SLOT, 8'd0, 8'd0, 4'd1, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_SET_SLOT, 8'd0, 8'd200, 4'd2, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd5, 8'd200, 4'd0, 24'd10, 1'b1);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd5, 8'd0, 4'd0, 24'd10, 1'b1);
    add_item(pmca_pkg::OP_QUERY, 8'd5, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_WRITE_DIST, 8'd5, 8'd200, 4'd0, 24'd9, 1'b1);
    add_item(pmca_pkg::OP_QUERY, 8'd5, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_QUERY, 8'd7, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_EVALUATE, 8'd0, 8'd0, 4'd0, 24'd0, 1'b0);
    add_item(pmca_pkg::OP_QUERY, 8'd255, 8'd0, 4'd0, 24'd0, 1'b0);
    drain();

    for (ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin cost = 16'd0; cc = 16'd1; mc = 16'd1; end
        1: begin cost = 16'hFFFF; cc = 16'd256; mc = 16'd16; end
        2: begin cost = 16'd256; cc = 16'd0; mc = 16'd0; end
        4: begin cost = 16'($urandom_range(65535)); cc = 16'd511; mc = 16'd31; end
        default: begin
          cost = 16'($urandom_range(65535));
          cc = 16'($urandom_range(1, 12));
          mc = 16'($urandom_range(1, 6));
        end
      endcase
      write_reg(pmca_pkg::CFG_COST_PER_KM, cost);
      write_reg(pmca_pkg::CFG_CUSTOMER_COUNT, cc);
      write_reg(pmca_pkg::CFG_MEDIAN_COUNT, mc);
      n = (cc[8:0] > 256) ? 256 : int'(cc[8:0]);
      m = (mc[4:0] > 16) ? 16 : int'(mc[4:0]);
      quiet = (ph == 5);
      if (ph == 3) hold_go = 1'b1;
      plan_phase(125, (n + 2 > 256) ? 256 : n + 2, m, n * m > 200);
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
